// ----- sv/shra_pkg.sv -----
package shra_pkg;

  localparam int CMD_W    = 3;
  localparam int SAMPLE_W = 16;
  localparam int AMOUNT_W = 32;
  localparam int POS_W    = 18;
  localparam int BIN_W    = 19;
  localparam int CFG_W    = 11;
  localparam int OUT_W    = 24;
  localparam int CNT_W    = 11;
  localparam int FRAME_W  = 2 * SAMPLE_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_READ  = 3'd2,
    CMD_AVG   = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_e_t;

  typedef struct packed {
    logic [CMD_W-1:0]           command;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic [AMOUNT_W-1:0]        block_amount;
    logic [POS_W-1:0]           position;
    logic [BIN_W-1:0]           bin_width;
  } item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] left_out;
    logic signed [OUT_W-1:0] right_out;
    logic [CNT_W-1:0]        frames_used;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_start;
    logic clr_step;
    logic do_begin;
    logic do_write;
    logic item_start;
    logic item_avg;
    logic mod_step;
    logic sum_start;
    logic sum_step;
    logic div_start;
    logic div_step;
    logic load_out;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic mod_done;
    logic sum_done;
    logic div_done;
  } stat_t;

endpackage

// ----- sv/stereo_history_ring_averager.sv -----
// Begin, write and unused commands finish in the idle state; writes stream one beat a cycle
// while no read, average or clearing pass holds the stall. A read finds its start slot by a
// bit-serial modulo over XW bits, XW = max(log2 DEPTH, 18 - FRAC_BITS) + 1, then reads one frame.
// Average: the same modulo, then n frame reads through the single read port, then a
// 36-bit bit-serial divide. One item is worked on at a time.
// Reset, a clear command and a size write start a clearing pass over all DEPTH slots.
module stereo_history_ring_averager #(
  parameter int DEPTH     = 1024,
  parameter int FRAC_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  shra_pkg::item_t            item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output shra_pkg::result_t          result,
  input  logic                       buffer_frames_we,
  input  logic [shra_pkg::CFG_W-1:0] buffer_frames_data
);
  import shra_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  shra_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .command          (item.command),
    .buffer_frames_we (buffer_frames_we),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .ctl              (ctl),
    .stat             (stat)
  );

  shra_datapath #(
    .DEPTH     (DEPTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .item               (item),
    .buffer_frames_we   (buffer_frames_we),
    .buffer_frames_data (buffer_frames_data),
    .ctl                (ctl),
    .stat               (stat),
    .result             (result)
  );

endmodule

// ----- sv/shra_datapath.sv -----
module shra_datapath #(
  parameter int DEPTH     = 1024,
  parameter int FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  shra_pkg::item_t                item,
  input  logic                           buffer_frames_we,
  input  logic [shra_pkg::CFG_W-1:0]     buffer_frames_data,
  input  shra_pkg::ctl_t                 ctl,
  output shra_pkg::stat_t                stat,
  output shra_pkg::result_t              result
);
  import shra_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int SZW  = $clog2(DEPTH + 1);
  localparam int PW   = POS_W - FRAC_BITS;
  localparam int NW   = BIN_W + 1 - FRAC_BITS;
  localparam int SW   = SAMPLE_W + NW;
  localparam int DVW  = SW + FRAC_BITS;
  localparam int XW   = ((AW > PW) ? AW : PW) + 1;
  localparam int MCW  = $clog2(XW + 1);
  localparam int DCW  = $clog2(DVW + 1);
  localparam int NFW  = BIN_W + 1;
  localparam logic [NFW-1:0] FRAC_MASK = NFW'((64'd1 << FRAC_BITS) - 64'd1);

  logic [FRAME_W-1:0] mem [DEPTH];
  logic [FRAME_W-1:0] rd_data;

  logic [SZW-1:0]      size;
  logic [AW-1:0]       wp;
  logic [AMOUNT_W-1:0] skip;
  logic [AW-1:0]       clr_addr;

  logic [XW-1:0]  x;
  logic [SZW-1:0] rem;
  logic [MCW-1:0] mod_cnt;

  logic [NW-1:0]        n;
  logic [NW-1:0]        issue_cnt;
  logic [AW-1:0]        rd_addr;
  logic                 pend;
  logic signed [SW-1:0] sum_l;
  logic signed [SW-1:0] sum_r;

  logic [DVW-1:0] ql;
  logic [DVW-1:0] qr;
  logic [NW-1:0]  rl;
  logic [NW-1:0]  rr;
  logic           neg_l;
  logic           neg_r;
  logic [DCW-1:0] div_cnt;

  logic [CFG_W-1:0] cfg_clamped;
  logic [SZW-1:0]   wp_inc;
  logic [SZW-1:0]   rd_inc;
  logic [SZW:0]     rem_sh;
  logic [SZW-1:0]   rem_next;
  logic [PW-1:0]    pint;
  logic [NFW-1:0]   span_sum;
  logic [NW-1:0]    n_raw;
  logic [NW-1:0]    n_eff;
  logic [SW-1:0]    mag_l;
  logic [SW-1:0]    mag_r;
  logic [NW:0]      rl_sh;
  logic [NW:0]      rr_sh;
  logic             ge_l;
  logic             ge_r;
  logic [OUT_W-1:0] ql_out;
  logic [OUT_W-1:0] qr_out;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [FRAME_W-1:0] mem_wdata;

  always_comb begin
    if (buffer_frames_data == '0) begin
      cfg_clamped = CFG_W'(1);
    end else if (32'(buffer_frames_data) > 32'(DEPTH)) begin
      cfg_clamped = CFG_W'(DEPTH);
    end else begin
      cfg_clamped = buffer_frames_data;
    end
  end

  assign wp_inc = SZW'(wp) + SZW'(1);
  assign rd_inc = SZW'(rd_addr) + SZW'(1);

  assign rem_sh   = {rem, x[XW-1]};
  assign rem_next = (rem_sh >= {1'b0, size}) ? SZW'(rem_sh - {1'b0, size}) : SZW'(rem_sh);

  assign pint     = PW'(item.position >> FRAC_BITS);
  assign span_sum = NFW'(item.bin_width) + (NFW'(item.position) & FRAC_MASK);
  assign n_raw    = NW'(span_sum >> FRAC_BITS);
  assign n_eff    = (n_raw == '0) ? NW'(1) : n_raw;

  assign mag_l = sum_l[SW-1] ? SW'(-sum_l) : SW'(sum_l);
  assign mag_r = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);

  assign rl_sh = {rl, ql[DVW-1]};
  assign rr_sh = {rr, qr[DVW-1]};
  assign ge_l  = rl_sh >= {1'b0, n};
  assign ge_r  = rr_sh >= {1'b0, n};

  assign ql_out = neg_l ? OUT_W'(-ql[OUT_W-1:0]) : ql[OUT_W-1:0];
  assign qr_out = neg_r ? OUT_W'(-qr[OUT_W-1:0]) : qr[OUT_W-1:0];

  assign mem_we    = ctl.clr_step || (ctl.do_write && skip == '0);
  assign mem_waddr = ctl.clr_step ? clr_addr : wp;
  assign mem_wdata = ctl.clr_step ? '0 : {item.left_in, item.right_in};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  assign stat.clr_last = (clr_addr == AW'(DEPTH - 1));
  assign stat.mod_done = (mod_cnt == '0);
  assign stat.sum_done = (issue_cnt == '0) && !pend;
  assign stat.div_done = (div_cnt == '0);

  // ring control state
  always_ff @(posedge clk) begin
    if (rst) begin
      size     <= SZW'(DEPTH);
      wp       <= '0;
      skip     <= '0;
      clr_addr <= '0;
    end else begin
      if (buffer_frames_we) begin
        size <= SZW'(cfg_clamped);
      end
      if (ctl.clr_start) begin
        wp       <= '0;
        skip     <= '0;
        clr_addr <= '0;
      end else begin
        if (ctl.clr_step) begin
          clr_addr <= stat.clr_last ? '0 : AW'(clr_addr + AW'(1));
        end
        if (ctl.do_begin) begin
          skip <= (item.block_amount > AMOUNT_W'(size))
                  ? AMOUNT_W'(item.block_amount - AMOUNT_W'(size)) : '0;
        end
        if (ctl.do_write) begin
          if (skip != '0) begin
            skip <= skip - AMOUNT_W'(1);
          end else begin
            wp <= (wp_inc >= size) ? '0 : AW'(wp_inc);
          end
        end
      end
    end
  end

  // slot = (wp + integer position) mod size, one bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      mod_cnt <= '0;
    end else if (ctl.item_start) begin
      mod_cnt <= MCW'(XW);
    end else if (ctl.mod_step) begin
      mod_cnt <= mod_cnt - MCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.item_start) begin
      x   <= XW'(wp) + XW'(pint);
      rem <= '0;
      n   <= ctl.item_avg ? n_eff : NW'(1);
    end else if (ctl.mod_step) begin
      x   <= {x[XW-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  // span accumulation: issue one read a cycle, add its data in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      pend      <= 1'b0;
    end else if (ctl.sum_start) begin
      issue_cnt <= n;
      pend      <= 1'b0;
    end else if (ctl.sum_step) begin
      if (issue_cnt != '0) begin
        issue_cnt <= issue_cnt - NW'(1);
        pend      <= 1'b1;
      end else begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sum_start) begin
      rd_addr <= AW'(rem);
      sum_l   <= '0;
      sum_r   <= '0;
    end else if (ctl.sum_step) begin
      if (issue_cnt != '0) begin
        rd_addr <= (rd_inc >= size) ? '0 : AW'(rd_inc);
      end
      if (pend) begin
        sum_l <= sum_l + SW'($signed(rd_data[FRAME_W-1:SAMPLE_W]));
        sum_r <= sum_r + SW'($signed(rd_data[SAMPLE_W-1:0]));
      end
    end
  end

  // sign-magnitude restoring divide of (sum << FRAC_BITS) by n, both channels
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (ctl.div_start) begin
      div_cnt <= DCW'(DVW);
    end else if (ctl.div_step) begin
      div_cnt <= div_cnt - DCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      ql    <= DVW'(mag_l) << FRAC_BITS;
      qr    <= DVW'(mag_r) << FRAC_BITS;
      rl    <= '0;
      rr    <= '0;
      neg_l <= sum_l[SW-1];
      neg_r <= sum_r[SW-1];
    end else if (ctl.div_step) begin
      ql <= {ql[DVW-2:0], ge_l};
      qr <= {qr[DVW-2:0], ge_r};
      rl <= ge_l ? NW'(rl_sh - {1'b0, n}) : NW'(rl_sh);
      rr <= ge_r ? NW'(rr_sh - {1'b0, n}) : NW'(rr_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      if (ctl.item_avg) begin
        result.left_out  <= ql_out;
        result.right_out <= qr_out;
      end else begin
        result.left_out  <= OUT_W'(sum_l) <<< FRAC_BITS;
        result.right_out <= OUT_W'(sum_r) <<< FRAC_BITS;
      end
      result.frames_used <= CNT_W'(n);
    end
  end

endmodule

// ----- sv/shra_ctrl.sv -----
module shra_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [shra_pkg::CMD_W-1:0] command,
  input  logic                       buffer_frames_we,
  output logic                       result_valid,
  input  logic                       result_stall,
  output shra_pkg::ctl_t             ctl,
  input  shra_pkg::stat_t            stat
);
  import shra_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_MOD   = 6'b000100,
    ST_SUM   = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   avg;
  logic   accept;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;

  always_comb begin
    ctl          = '0;
    ctl.item_avg = avg;
    state_next   = state;
    unique case (state)
      ST_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_e_t'(command))
            CMD_BEGIN: ctl.do_begin = 1'b1;
            CMD_WRITE: ctl.do_write = 1'b1;
            CMD_READ: begin
              ctl.item_start = 1'b1;
              ctl.item_avg   = 1'b0;
              state_next     = ST_MOD;
            end
            CMD_AVG: begin
              ctl.item_start = 1'b1;
              ctl.item_avg   = 1'b1;
              state_next     = ST_MOD;
            end
            CMD_CLEAR: begin
              ctl.clr_start = 1'b1;
              state_next    = ST_CLEAR;
            end
            default: ;
          endcase
        end
      end
      ST_MOD: begin
        if (stat.mod_done) begin
          ctl.sum_start = 1'b1;
          state_next    = ST_SUM;
        end else begin
          ctl.mod_step = 1'b1;
        end
      end
      ST_SUM: begin
        if (stat.sum_done) begin
          if (avg) begin
            ctl.div_start = 1'b1;
            state_next    = ST_DIV;
          end else begin
            state_next = ST_DONE;
          end
        end else begin
          ctl.sum_step = 1'b1;
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_next = ST_DONE;
        end else begin
          ctl.div_step = 1'b1;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!result_valid || !result_stall) begin
          ctl.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase

    // a size write restarts the clearing pass
    if (buffer_frames_we) begin
      ctl           = '0;
      ctl.item_avg  = avg;
      ctl.clr_start = 1'b1;
      state_next    = ST_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      avg          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.item_start) begin
        avg <= ctl.item_avg;
      end
      if (ctl.load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule
